/* sv/thbr_pkg.sv */
package thbr_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int TIME_WIDTH_DEF = 32;

  // Fixed field widths at the ports
  localparam int NOW_W    = 32;
  localparam int SAMPLE_W = 64;
  localparam int AGE_W    = 8;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int STEP_W   = 32;
  localparam int LIMIT_W  = 9;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT = 1'b1;

  // Request opcodes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Controller -> datapath commands, at most one per cycle
  typedef struct packed {
    logic load;
    logic rd_age;
    logic rd_newest;
    logic cap_last;
    logic mk_base;
    logic check;
    logic open_rec;
    logic write;
    logic finish;
  } thbr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_read;
    logic read_hit;
    logic total_zero;
    logic step_zero;
    logic div_busy;
    logic out_free;
  } thbr_status_t;

endpackage

/* sv/thbr_ram.sv */
module thbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/thbr_rem_div.sv */
// Bit-serial restoring remainder: one dividend bit per cycle.
module thbr_rem_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     dvd_r;
  logic [W-1:0]     dvs_r;
  logic [W-1:0]     rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [W:0]       shifted;
  logic [W:0]       trial;

  assign shifted = {rem_r, dvd_r[W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_r <= trial[W-1:0];
      end else begin
        rem_r <= shifted[W-1:0];
      end
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

/* sv/thbr_ctrl.sv */
module thbr_ctrl import thbr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  thbr_status_t st_i,
  output thbr_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_RWAIT = 4'd2;
  localparam logic [3:0] S_LAST  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_BASE  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_OPEN  = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        if (st_i.is_read) begin
          if (st_i.read_hit) begin
            cmd_o.rd_age = 1'b1;
            state_nxt    = S_RWAIT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (st_i.total_zero) begin
          state_nxt = S_OPEN;
        end else begin
          cmd_o.rd_newest = 1'b1;
          state_nxt       = S_LAST;
        end
      end
      S_RWAIT: state_nxt = S_DONE;
      S_LAST: begin
        cmd_o.cap_last = 1'b1;
        state_nxt      = st_i.step_zero ? S_CHECK : S_DIV;
      end
      S_DIV: begin
        if (!st_i.div_busy) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        cmd_o.mk_base = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_nxt   = S_OPEN;
      end
      S_OPEN: begin
        cmd_o.open_rec = 1'b1;
        state_nxt      = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd_o))
    else $error("more than one datapath command in a cycle");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !st_i.out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output register full");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !st_i.div_busy) |=> (state_r == S_BASE))
    else $error("divider finish not followed by base step");

endmodule

/* sv/thbr_dp.sv */
module thbr_dp import thbr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_cmd,
  input  logic [NOW_W-1:0]     in_now_time,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic [AGE_W-1:0]     in_age_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    out_slot_written,
  output logic                 out_opened_record,
  output logic                 out_recycled_oldest,
  output logic [NOW_W-1:0]     out_closed_time,
  output logic [COUNT_W-1:0]   out_held_count,
  output logic [NOW_W-1:0]     out_read_time,
  output logic [SAMPLE_W-1:0]  out_read_value,
  output logic                 out_read_valid,
  input  thbr_cmd_t            cmd_i,
  output thbr_status_t         st_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int TW = TIME_WIDTH;
  localparam int DW = DATA_WIDTH;
  localparam int RW = TW + DW;
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_SC = SW'(DEPTH);

  // (a + b) mod DEPTH, with a < DEPTH and b <= DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [SW-1:0] b);
    logic [SW-1:0] sum;
    sum = SW'(a) + b;
    if (sum >= DEPTH_SC) begin
      sum = sum - DEPTH_SC;
    end
    return AW'(sum);
  endfunction

  // configuration
  logic [STEP_W-1:0]  step_r;
  logic [LIMIT_W-1:0] limit_r;

  // request
  logic              cmd_r;
  logic [TW-1:0]     now_r;
  logic [DW-1:0]     data_r;
  logic [AGE_W-1:0]  age_r;

  // ring pointers
  logic [AW-1:0]     oldest_r;
  logic [CW-1:0]     total_r;

  // append working set
  logic [TW-1:0]     last_r;
  logic [DW-1:0]     lastval_r;
  logic [TW-1:0]     base_r;
  logic [TW-1:0]     closed_r;
  logic [AW-1:0]     slot_r;
  logic              open_r;
  logic              recyc_r;

  logic              out_valid_r;
  logic [SLOT_W-1:0] slot_out_r;
  logic              opened_out_r;
  logic              recyc_out_r;
  logic [NOW_W-1:0]  closed_out_r;
  logic [COUNT_W-1:0] held_out_r;
  logic [NOW_W-1:0]  rtime_out_r;
  logic [SAMPLE_W-1:0] rval_out_r;
  logic              rvalid_out_r;

  logic [TW-1:0]     step_w;
  logic              step_zero;
  logic              read_hit;
  logic [CW-1:0]     lim_w;
  logic [AW-1:0]     age_slot;
  logic [AW-1:0]     newest_slot;
  logic [TW-1:0]     rd_time;
  logic [DW-1:0]     rd_val;
  logic [RW-1:0]     ram_rdata;
  logic [RW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic              ram_we;
  logic              ram_re;
  logic              same;
  logic [TW-1:0]     closed_w;
  logic              close_we;
  logic [TW-1:0]     div_rem;
  logic              div_busy;

  assign step_w    = TW'(step_r);
  assign step_zero = (step_w == '0);
  assign read_hit  = (32'(age_r) < 32'(total_r));
  assign age_slot  = wrap_add(oldest_r, SW'(age_r));
  assign newest_slot = wrap_add(oldest_r, SW'(total_r) - SW'(1));
  assign rd_time   = ram_rdata[RW-1:DW];
  assign rd_val    = ram_rdata[DW-1:0];

  // effective record limit, 1..DEPTH
  always_comb begin
    if (limit_r == '0) begin
      lim_w = CW'(1);
    end else if (32'(limit_r) > DEPTH) begin
      lim_w = DEPTH_C;
    end else begin
      lim_w = CW'(limit_r);
    end
  end

  // same if base<=now<base+step, base=last-(last mod step); step 0: now==last
  always_comb begin
    if (step_zero) begin
      same     = (last_r == now_r);
      closed_w = last_r;
    end else begin
      same     = (now_r >= base_r) && ((now_r - base_r) < step_w);
      closed_w = base_r + step_w;
    end
  end

  assign close_we  = cmd_i.check && !same;
  assign ram_we    = close_we || cmd_i.write;
  assign ram_waddr = cmd_i.write ? newest_slot : newest_slot;
  assign ram_wdata = cmd_i.write ? {now_r, data_r} : {closed_w, lastval_r};
  assign ram_re    = cmd_i.rd_age || cmd_i.rd_newest;
  assign ram_raddr = cmd_i.rd_age ? age_slot : newest_slot;

  thbr_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  thbr_rem_div #(
    .W (TW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_i.cap_last && !step_zero),
    .dividend (rd_time),
    .divisor  (step_w),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // configuration and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      limit_r  <= LIMIT_W'(256);
      oldest_r <= '0;
      total_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_STEP:    step_r  <= cfg_wdata;
          REG_RECORD_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.open_rec && open_r) begin
        if (total_r >= lim_w) begin
          oldest_r <= wrap_add(oldest_r, SW'(total_r) - SW'(lim_w) + SW'(1));
          total_r  <= lim_w;
        end else begin
          total_r <= total_r + CW'(1);
        end
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r    <= in_cmd;
      now_r    <= TW'(in_now_time);
      data_r   <= DW'(in_sample_value);
      age_r    <= in_age_index;
      open_r   <= (in_cmd == CMD_APPEND) && (total_r == '0);
      recyc_r  <= 1'b0;
      closed_r <= '0;
    end
    if (cmd_i.cap_last) begin
      last_r    <= rd_time;
      lastval_r <= rd_val;
    end
    if (cmd_i.mk_base) begin
      base_r <= last_r - div_rem;
    end
    if (close_we) begin
      open_r   <= 1'b1;
      closed_r <= closed_w;
    end
    if (cmd_i.open_rec && open_r && (total_r >= lim_w)) begin
      recyc_r <= 1'b1;
    end
    if (cmd_i.write) begin
      slot_r <= newest_slot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      held_out_r <= COUNT_W'(total_r);
      if (cmd_r == CMD_READ) begin
        slot_out_r   <= '0;
        opened_out_r <= 1'b0;
        recyc_out_r  <= 1'b0;
        closed_out_r <= '0;
        rvalid_out_r <= read_hit;
        rtime_out_r  <= read_hit ? NOW_W'(rd_time) : '0;
        rval_out_r   <= read_hit ? SAMPLE_W'(rd_val) : '0;
      end else begin
        slot_out_r   <= SLOT_W'(slot_r);
        opened_out_r <= open_r;
        recyc_out_r  <= recyc_r;
        closed_out_r <= NOW_W'(closed_r);
        rvalid_out_r <= 1'b0;
        rtime_out_r  <= '0;
        rval_out_r   <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_written    = slot_out_r;
  assign out_opened_record   = opened_out_r;
  assign out_recycled_oldest = recyc_out_r;
  assign out_closed_time     = closed_out_r;
  assign out_held_count      = held_out_r;
  assign out_read_time       = rtime_out_r;
  assign out_read_value      = rval_out_r;
  assign out_read_valid      = rvalid_out_r;

  always_comb begin
    st_o            = '0;
    st_o.is_read    = (cmd_r == CMD_READ);
    st_o.read_hit   = read_hit;
    st_o.total_zero = (total_r == '0);
    st_o.step_zero  = step_zero;
    st_o.div_busy   = div_busy;
    st_o.out_free   = !out_valid_r || !out_stall;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= DEPTH_C)
    else $error("record count above ring depth");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |=> out_valid_r)
    else $error("finished request not presented");

  a_open_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.open_rec && open_r) |=> (total_r != '0))
    else $error("ring empty after opening a record");

endmodule

/* sv/time_bucketed_history_ring_core.sv */
// Path, accept to out_valid: read hit FETCH, RWAIT, DONE; read miss FETCH, DONE; append
//   to an empty ring FETCH, OPEN, WRITE, DONE; zero-step append FETCH, LAST, CHECK, OPEN,
//   WRITE, DONE; nonzero step adds DIV (waiting on the bit-serial remainder) and BASE.
// Flow: one request at a time; in_stall holds off the next until its result is registered.
// Reset (rst_n low, synchronous) empties the ring, restores step 0 and limit 256 and
//   leaves ring memory as it is (no clearing pass).
module time_bucketed_history_ring_core import thbr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration: index 0 time_step, index 1 record_limit
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [NOW_W-1:0]     in_now_time,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic [AGE_W-1:0]     in_age_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    out_slot_written,
  output logic                 out_opened_record,
  output logic                 out_recycled_oldest,
  output logic [NOW_W-1:0]     out_closed_time,
  output logic [COUNT_W-1:0]   out_held_count,
  output logic [NOW_W-1:0]     out_read_time,
  output logic [SAMPLE_W-1:0]  out_read_value,
  output logic                 out_read_valid
);

  // Controller sequences each request through the datapath:
  //   read  : fetch slot (oldest + age) on a hit -> wait for RAM data -> present
  //   append: fetch newest record if any -> remainder of its time by the step
  //           -> bucket base (both skipped at step 0) -> same-bucket check (if not,
  //           close at bucket end/last time) -> open/recycle -> write sample -> present
  thbr_cmd_t    cmd;
  thbr_status_t st;

  thbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  // Datapath holds config, ring pointers, the record RAM (time and data
  // side by side), the remainder unit and the output register.
  thbr_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_cmd              (in_cmd),
    .in_now_time         (in_now_time),
    .in_sample_value     (in_sample_value),
    .in_age_index        (in_age_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slot_written    (out_slot_written),
    .out_opened_record   (out_opened_record),
    .out_recycled_oldest (out_recycled_oldest),
    .out_closed_time     (out_closed_time),
    .out_held_count      (out_held_count),
    .out_read_time       (out_read_time),
    .out_read_value      (out_read_value),
    .out_read_valid      (out_read_valid),
    .cmd_i               (cmd),
    .st_o                (st)
  );

endmodule

/* tb/ring_history_checker.sv */
module ring_history_checker import thbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [NOW_W-1:0]     in_now_time,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic [AGE_W-1:0]     in_age_index,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SLOT_W-1:0]    out_slot_written,
  input  logic                 out_opened_record,
  input  logic                 out_recycled_oldest,
  input  logic [NOW_W-1:0]     out_closed_time,
  input  logic [COUNT_W-1:0]   out_held_count,
  input  logic [NOW_W-1:0]     out_read_time,
  input  logic [SAMPLE_W-1:0]  out_read_value,
  input  logic                 out_read_valid,
  output int                   fail_count,
  output int                   pending,
  output int                   results_checked,
  output int                   opens_seen,
  output int                   recycles_seen,
  output int                   hits_seen
);

  localparam int RING_SLOTS = 256;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                opened;
    logic                recycled;
    logic [NOW_W-1:0]    closed;
    logic [COUNT_W-1:0]  held;
    logic [NOW_W-1:0]    rtime;
    logic [SAMPLE_W-1:0] rvalue;
    logic                rvalid;
  } ring_result_t;

  logic [NOW_W-1:0]    time_mem  [RING_SLOTS];
  logic [SAMPLE_W-1:0] value_mem [RING_SLOTS];
  logic [SLOT_W-1:0]   oldest;
  logic [COUNT_W-1:0]  total;
  logic [STEP_W-1:0]   step_reg;
  logic [LIMIT_W-1:0]  limit_reg;

  ring_result_t awaited_results[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    opens_seen      = 0;
    recycles_seen   = 0;
    hits_seen       = 0;
  end

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    fail_count++;
    $display("MISMATCH %s at result %0d: got %h expected %h",
             what, results_checked, got, want);
  endtask

  // Applies one request to the shadow ring and returns what it should produce.
  function automatic ring_result_t advance_ring(input logic cmd,
                                                input logic [NOW_W-1:0] now,
                                                input logic [SAMPLE_W-1:0] sample,
                                                input logic [AGE_W-1:0] age);
    ring_result_t        r;
    logic                open_new;
    logic                same;
    logic [SLOT_W-1:0]   newest;
    logic [SLOT_W-1:0]   slot;
    logic [NOW_W-1:0]    last;
    logic [NOW_W-1:0]    closed;
    logic [COUNT_W-1:0]  lim;
    logic [COUNT_W-1:0]  drop;
    r = '0;
    if (cmd == CMD_APPEND) begin
      open_new = 1'b0;
      if (total == '0) begin
        open_new = 1'b1;
      end else begin
        newest = oldest + SLOT_W'(total - 1'b1);
        last   = time_mem[newest];
        same   = (step_reg != '0) ? (last / step_reg == now / step_reg) : (last == now);
        if (!same) begin
          // next bucket's start (wraps at the time width); step 0 keeps last
          closed = (step_reg != '0) ? (last - (last % step_reg) + step_reg) : last;
          time_mem[newest] = closed;
          r.closed = closed;
          open_new = 1'b1;
        end
      end
      if (open_new) begin
        lim = (limit_reg == '0) ? COUNT_W'(1) :
              (limit_reg > COUNT_W'(RING_SLOTS)) ? COUNT_W'(RING_SLOTS) : limit_reg;
        if (total >= lim) begin
          drop   = total - lim + 1'b1;
          oldest = oldest + drop[SLOT_W-1:0];
          total  = lim - 1'b1;
          r.recycled = 1'b1;
        end
        total = total + 1'b1;
        r.opened = 1'b1;
      end
      slot = oldest + SLOT_W'(total - 1'b1);
      time_mem[slot]  = now;
      value_mem[slot] = sample;
      r.slot = slot;
    end else if (COUNT_W'(age) < total) begin
      slot     = oldest + age;
      r.rtime  = time_mem[slot];
      r.rvalue = value_mem[slot];
      r.rvalid = 1'b1;
    end
    r.held = total;
    return r;
  endfunction

  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    if (!rst_n) begin
      oldest    = '0;
      total     = '0;
      step_reg  = '0;
      limit_reg = COUNT_W'(RING_SLOTS);
      awaited_results.delete();
    end else begin
      // results first: one accepted now belongs to an older request
      if (out_valid && !out_stall) begin
        got = '{out_slot_written, out_opened_record, out_recycled_oldest, out_closed_time,
                out_held_count, out_read_time, out_read_value, out_read_valid};
        if (awaited_results.size() == 0) begin
          note_mismatch("result with no request waiting", 64'(out_held_count), 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (got.slot != want.slot)
            note_mismatch("slot_written", 64'(got.slot), 64'(want.slot));
          if (got.opened != want.opened)
            note_mismatch("opened_record", 64'(got.opened), 64'(want.opened));
          if (got.recycled != want.recycled)
            note_mismatch("recycled_oldest", 64'(got.recycled), 64'(want.recycled));
          if (got.closed != want.closed)
            note_mismatch("closed_time", 64'(got.closed), 64'(want.closed));
          if (got.held != want.held)
            note_mismatch("held_count", 64'(got.held), 64'(want.held));
          if (got.rtime != want.rtime)
            note_mismatch("read_time", 64'(got.rtime), 64'(want.rtime));
          if (got.rvalue != want.rvalue)
            note_mismatch("read_value", got.rvalue, want.rvalue);
          if (got.rvalid != want.rvalid)
            note_mismatch("read_valid", 64'(got.rvalid), 64'(want.rvalid));
          results_checked++;
          opens_seen    += want.opened;
          recycles_seen += want.recycled;
          hits_seen     += want.rvalid;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_TIME_STEP)
          step_reg = cfg_wdata[STEP_W-1:0];
        else if (cfg_index == REG_RECORD_LIMIT)
          limit_reg = cfg_wdata[LIMIT_W-1:0];
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(advance_ring(in_cmd, in_now_time, in_sample_value,
                                               in_age_index));
    end
    pending <= awaited_results.size();
  end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the bucketed history ring. The checker beside the
// core shadows the ring and compares every result; this module only makes
// requests, shapes the flow on both channels and judges the run.
module tb_top import thbr_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;

  // receiver flow modes for the result channel
  typedef enum logic [1:0] {FLOW_FREE, FLOW_CHOPPY, FLOW_CLOGGED} flow_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_APPEND;
  logic [NOW_W-1:0]     in_now_time = '0;
  logic [SAMPLE_W-1:0]  in_sample_value = '0;
  logic [AGE_W-1:0]     in_age_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SLOT_W-1:0]    out_slot_written;
  logic                 out_opened_record;
  logic                 out_recycled_oldest;
  logic [NOW_W-1:0]     out_closed_time;
  logic [COUNT_W-1:0]   out_held_count;
  logic [NOW_W-1:0]     out_read_time;
  logic [SAMPLE_W-1:0]  out_read_value;
  logic                 out_read_valid;

  int fail_count;
  int pending;
  int results_checked;
  int opens_seen;
  int recycles_seen;
  int hits_seen;

  int              cycles = 0;
  int              requests_sent = 0;
  int              burst_left = 0;
  logic [NOW_W-1:0] cur_time = '0;   // running sample clock for well-formed appends
  flow_mode_t      flow_mode = FLOW_FREE;
  int              flow_hold = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  time_bucketed_history_ring_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_now_time         (in_now_time),
    .in_sample_value     (in_sample_value),
    .in_age_index        (in_age_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slot_written    (out_slot_written),
    .out_opened_record   (out_opened_record),
    .out_recycled_oldest (out_recycled_oldest),
    .out_closed_time     (out_closed_time),
    .out_held_count      (out_held_count),
    .out_read_time       (out_read_time),
    .out_read_value      (out_read_value),
    .out_read_valid      (out_read_valid)
  );

  ring_history_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_now_time         (in_now_time),
    .in_sample_value     (in_sample_value),
    .in_age_index        (in_age_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slot_written    (out_slot_written),
    .out_opened_record   (out_opened_record),
    .out_recycled_oldest (out_recycled_oldest),
    .out_closed_time     (out_closed_time),
    .out_held_count      (out_held_count),
    .out_read_time       (out_read_time),
    .out_read_value      (out_read_value),
    .out_read_valid      (out_read_valid),
    .fail_count          (fail_count),
    .pending             (pending),
    .results_checked     (results_checked),
    .opens_seen          (opens_seen),
    .recycles_seen       (recycles_seen),
    .hits_seen           (hits_seen)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result-channel backpressure: free flow, light chop, or mostly stalled,
  // each mode held for a random stretch.
  always @(posedge clk) begin
    if (flow_hold == 0) begin
      flow_mode <= flow_mode_t'($urandom_range(0, 2));
      flow_hold <= $urandom_range(30, 300);
    end else begin
      flow_hold <= flow_hold - 1;
    end
    case (flow_mode)
      FLOW_FREE:   out_stall <= 1'b0;
      FLOW_CHOPPY: out_stall <= ($urandom_range(0, 2) == 0);
      default:     out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // One register write; the extra edge keeps cfg_we from being lowered and
  // raised in the same step on back-to-back writes.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and hold off until every awaited result is back. The first
  // edge lets the checker count a request accepted at the current edge.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Present one request and hold it until accepted; at the end of a burst
  // the sender goes quiet for a random gap.
  task automatic push_request(input logic cmd, input logic [NOW_W-1:0] now,
                              input logic [SAMPLE_W-1:0] sample,
                              input logic [AGE_W-1:0] age);
    int gap;
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_now_time     <= now;
    in_sample_value <= sample;
    in_age_index    <= age;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // long gaps land across the divider's whole run
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A random phase: mostly appends that walk the sample clock forward by up
  // to max_dt, reads biased toward held ages, and some appends at wild times.
  task automatic run_phase(input int count, input logic [STEP_W-1:0] step,
                           input logic [LIMIT_W-1:0] limit, input logic [NOW_W-1:0] max_dt,
                           input int age_hint);
    int               kind;
    logic [AGE_W-1:0] age;
    wait_idle();
    set_register(REG_TIME_STEP, step);
    // upper bits of the limit word are don't-care; toggle them anyway
    set_register(REG_RECORD_LIMIT,
                 {(CFG_W - LIMIT_W)'($urandom_range(0, 32'h7F_FFFF)), limit});
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        cur_time = cur_time + $urandom_range(0, max_dt);
        push_request(CMD_APPEND, cur_time, pick_sample(), AGE_W'($urandom));
      end else if (kind < 85) begin
        age = ($urandom_range(0, 1) == 0) ? AGE_W'($urandom_range(0, age_hint)) :
                                            AGE_W'($urandom_range(0, 255));
        push_request(CMD_READ, $urandom, {$urandom, $urandom}, age);
      end else begin
        // broken sequence: jump the clock anywhere, backward included
        cur_time = $urandom;
        push_request(CMD_APPEND, cur_time, pick_sample(), AGE_W'($urandom));
      end
      if ($urandom_range(0, 199) == 0)
        wait_idle();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, default settings (step 0, limit 256): empty read, first
    // append, exact-time merge, zero-step close, reads in and beyond range.
    push_request(CMD_READ,   32'd0,        64'd0,  8'd0);
    push_request(CMD_APPEND, 32'd1000,     '0,     8'd0);
    push_request(CMD_APPEND, 32'd1000,     '1,     8'd0);
    push_request(CMD_APPEND, 32'd1001,     64'd5,  8'd0);
    push_request(CMD_READ,   32'd0,        64'd0,  8'd0);
    push_request(CMD_READ,   32'd0,        64'd0,  8'd1);
    push_request(CMD_READ,   32'd0,        64'd0,  8'd255);
    push_request(CMD_APPEND, 32'd0,        pick_sample(), 8'd0);

    // Step 100, limit 2 under three held records: the next opening drops two.
    wait_idle();
    set_register(REG_TIME_STEP, 32'd100);
    set_register(REG_RECORD_LIMIT, 32'd2);
    push_request(CMD_APPEND, 32'd150, pick_sample(), 8'd0);
    push_request(CMD_APPEND, 32'd199, pick_sample(), 8'd0);
    push_request(CMD_APPEND, 32'd250, pick_sample(), 8'd0);
    push_request(CMD_READ,   32'd0,   64'd0,         8'd0);
    push_request(CMD_READ,   32'd0,   64'd0,         8'd1);
    push_request(CMD_READ,   32'd0,   64'd0,         8'd2);

    // Huge step, limit above depth: bucket-start sum wraps past 2^32.
    wait_idle();
    set_register(REG_TIME_STEP, 32'hF000_0000);
    set_register(REG_RECORD_LIMIT, 32'd511);
    push_request(CMD_APPEND, 32'hFFFF_FFF0, pick_sample(), 8'd0);
    push_request(CMD_APPEND, 32'd5,         pick_sample(), 8'd0);
    push_request(CMD_APPEND, 32'hFFFF_FFFF, '1,            8'd0);
    push_request(CMD_READ,   32'd0,         64'd0,         8'd3);
    push_request(CMD_READ,   32'd0,         64'd0,         8'd2);

    // Maximum step: only the all-ones time leaves bucket zero.
    wait_idle();
    set_register(REG_TIME_STEP, 32'hFFFF_FFFF);
    push_request(CMD_APPEND, 32'hFFFF_FFFF, pick_sample(), 8'd0);
    push_request(CMD_APPEND, 32'd0,         pick_sample(), 8'd0);
    push_request(CMD_READ,   32'd0,         64'd0,         8'd0);
    push_request(CMD_READ,   32'd0,         64'd0,         8'd255);

    // Random phases. The first two fill the ring past its depth so it wraps,
    // then the limit is cut far below the held count.
    cur_time = 32'd10_000;
    run_phase(400, 32'd10,          9'd256, 32'd25,          255);
    run_phase(380, 32'd1,           9'd511, 32'd3,           255);
    run_phase(70,  32'hFFFF_FFFF,   9'd300, 32'h4000_0000,   255);
    run_phase(150, 32'd1000,        9'd3,   32'd3000,        5);
    run_phase(200, 32'd0,           9'd1,   32'd2,           3);
    run_phase(150, $urandom,        9'd0,   32'hFFFF_FFFF,   3);

    // Drain, then give a late stray result time to show up.
    wait_idle();
    repeat (60) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_checked, fail_count);
    $display("records opened %0d, recycled %0d, reads that hit %0d; steps 0 to max, limits 0 to 511",
             opens_seen, recycles_seen, hits_seen);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
